/* rtl/pmstep_pkg.sv */
// ----------------------------------------------------------------------------
// pmstep_pkg
// Shared types and codes for the pulsed motor stepper with limit stop.
// ----------------------------------------------------------------------------
package pmstep_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_ON_TICKS       = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_TICKS      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_TICKS = 2'd2;

  localparam logic [15:0] ON_TICKS_RST       = 16'd50;
  localparam logic [15:0] OFF_TICKS_RST      = 16'd50;
  localparam logic [7:0]  DEBOUNCE_TICKS_RST = 8'd10;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [1:0] {
    EDGE_NONE = 2'd0,
    EDGE_POS  = 2'd1,
    EDGE_NEG  = 2'd2
  } edge_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_t;

  typedef struct packed {
    logic        opcode;
    logic        direction;
    logic [15:0] step_count;
    logic        sw_pos;
    logic        sw_neg;
  } cmd_t;

  typedef struct packed {
    logic drive_pos;
    logic drive_neg;
    logic busy_res;
    logic done_res;
    logic reached_limit;
  } res_t;

endpackage

/* rtl/pulsed_motor_step_with_limit_stop_unit.sv */
// ----------------------------------------------------------------------------
// pulsed_motor_step_with_limit_stop_unit
// Timed motor pulses per start command, stopped early by debounced limit
// switches; one status result per transaction.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the command transaction.
// One transaction per cycle while results are taken; the only limit is the single
// result register, refilled in the cycle it is taken.
// Reset (rst, synchronous): idle, no recorded edge, switches released,
// debounce counter saturated, registers at defaults (50, 50, 10).
module pulsed_motor_step_with_limit_stop_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  pmstep_pkg::cmd_t             cmd,
  output logic                         res_valid,
  input  logic                         res_ready,
  output pmstep_pkg::res_t             res,
  input  logic                         cfg_wr_en,
  input  logic [pmstep_pkg::CfgIdxW-1:0]  cfg_addr,
  input  logic [pmstep_pkg::CfgDataW-1:0] cfg_wdata
);
  import pmstep_pkg::*;

  logic [15:0] on_ticks;
  logic [15:0] off_ticks;
  logic [7:0]  debounce_ticks;

  phase_t      phase, phase_next;
  logic [15:0] phase_left, phase_left_next;
  logic [15:0] pulses_left, pulses_left_next;
  logic        moving_positive, moving_positive_next;
  edge_t       recorded_edge, recorded_edge_next;
  logic        drive_cut, drive_cut_next;
  logic [1:0]  prev_switches, prev_switches_next;
  logic [7:0]  since_edge, since_edge_next;
  res_t        res_next;

  logic        accept;
  logic [7:0]  since_inc;
  logic [1:0]  sw;
  logic [15:0] left_dec;
  logic        advance;
  logic        done, reached, driving;
  edge_t       want;

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;

  always_comb begin
    phase_next           = phase;
    phase_left_next      = phase_left;
    pulses_left_next     = pulses_left;
    moving_positive_next = moving_positive;
    recorded_edge_next   = recorded_edge;
    drive_cut_next       = drive_cut;
    done                 = 1'b0;
    reached              = 1'b0;
    advance              = 1'b0;
    left_dec             = phase_left - 16'd1;
    want                 = moving_positive ? EDGE_POS : EDGE_NEG;
    sw                   = {cmd.sw_neg, cmd.sw_pos};

    if (cmd.opcode == OP_TICK && since_edge != 8'hFF) begin
      since_inc = since_edge + 8'd1;
    end else begin
      since_inc = since_edge;
    end

    // Debounced switch edge; counter restarts on every change.
    since_edge_next = since_inc;
    if (sw != prev_switches) begin
      if (since_inc > debounce_ticks) begin
        recorded_edge_next = cmd.sw_pos ? EDGE_POS : (cmd.sw_neg ? EDGE_NEG : EDGE_NONE);
        drive_cut_next     = 1'b1;
      end
      since_edge_next = 8'd0;
    end
    prev_switches_next = sw;

    if (cmd.opcode == OP_START) begin
      if (phase == PH_IDLE) begin
        moving_positive_next = cmd.direction;
        if (cmd.direction ? cmd.sw_pos : cmd.sw_neg) begin
          done    = 1'b1;
          reached = 1'b1;
        end else if (cmd.step_count == 16'd0) begin
          done = 1'b1;
        end else begin
          pulses_left_next = cmd.step_count - 16'd1;
          phase_next       = PH_ON;
          phase_left_next  = (on_ticks == 16'd0) ? 16'd1 : on_ticks;
          drive_cut_next   = 1'b0;
        end
      end
    end else begin
      case (phase)
        PH_ON: begin
          phase_left_next = left_dec;
          if (left_dec == 16'd0) begin
            if (recorded_edge_next == want) begin
              recorded_edge_next = EDGE_NONE;
              phase_next         = PH_IDLE;
              done               = 1'b1;
              reached            = 1'b1;
            end else if (off_ticks == 16'd0) begin
              advance = 1'b1;
            end else begin
              phase_next      = PH_OFF;
              phase_left_next = off_ticks;
            end
          end
        end
        PH_OFF: begin
          phase_left_next = left_dec;
          if (left_dec == 16'd0) begin
            advance = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // End of rest, or of a pulse with no rest: start the next pulse or finish.
    if (advance) begin
      if (pulses_left == 16'd0) begin
        phase_next = PH_IDLE;
        done       = 1'b1;
      end else begin
        pulses_left_next = pulses_left - 16'd1;
        phase_next       = PH_ON;
        phase_left_next  = (on_ticks == 16'd0) ? 16'd1 : on_ticks;
        drive_cut_next   = 1'b0;
      end
    end

    driving                = (phase_next == PH_ON) && !drive_cut_next;
    res_next.drive_pos     = driving && moving_positive_next;
    res_next.drive_neg     = driving && !moving_positive_next;
    res_next.busy_res      = (phase_next != PH_IDLE);
    res_next.done_res      = done;
    res_next.reached_limit = reached;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_ticks       <= ON_TICKS_RST;
      off_ticks      <= OFF_TICKS_RST;
      debounce_ticks <= DEBOUNCE_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_ON_TICKS:       on_ticks       <= cfg_wdata;
        CFG_OFF_TICKS:      off_ticks      <= cfg_wdata;
        CFG_DEBOUNCE_TICKS: debounce_ticks <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      phase_left      <= '0;
      pulses_left     <= '0;
      moving_positive <= 1'b0;
      recorded_edge   <= EDGE_NONE;
      drive_cut       <= 1'b0;
      prev_switches   <= 2'b00;
      since_edge      <= 8'hFF;
      res_valid       <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        phase_left      <= phase_left_next;
        pulses_left     <= pulses_left_next;
        moving_positive <= moving_positive_next;
        recorded_edge   <= recorded_edge_next;
        drive_cut       <= drive_cut_next;
        prev_switches   <= prev_switches_next;
        since_edge      <= since_edge_next;
        res_valid       <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_no_dual_drive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.drive_pos && res.drive_neg))
    else $error("both motor terminals driven");

  a_reached_with_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.reached_limit |-> res.done_res && !res.busy_res)
    else $error("reached_limit without a finished command");

  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> res.busy_res == (phase != PH_IDLE))
    else $error("busy result disagrees with phase");

  a_switch_change_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && ({cmd.sw_neg, cmd.sw_pos} != prev_switches) |=> since_edge == 8'd0)
    else $error("debounce counter not restarted on switch change");
`endif

endmodule

/* test/tb_pulsed_motor_step_with_limit_stop_unit.sv */
// ----------------------------------------------------------------------------
// tb_pulsed_motor_step_with_limit_stop_unit
// Self-checking bench for the pulsed motor stepper. Commands and ticks are
// driven over the valid/ready input, and every status result is compared
// field by field against an in-bench model of the pulse timing, debounce
// and limit stop. It runs several register settings, the extremes among
// them, most of them under random stalls on both channels.
// ----------------------------------------------------------------------------

class motor_scoreboard;
  logic [15:0]         on_ticks;
  logic [15:0]         off_ticks;
  logic [7:0]          debounce;
  pmstep_pkg::phase_t  phase;
  logic [15:0]         phase_left;
  logic [15:0]         pulses_left;
  logic                moving_pos;
  pmstep_pkg::edge_t   rec_edge;
  logic                drive_cut;
  logic [1:0]          prev_sw;
  logic [7:0]          since_edge;
  pmstep_pkg::res_t    status_q[$];
  int                  errors;

  function new();
    on_ticks    = pmstep_pkg::ON_TICKS_RST;
    off_ticks   = pmstep_pkg::OFF_TICKS_RST;
    debounce    = pmstep_pkg::DEBOUNCE_TICKS_RST;
    phase       = pmstep_pkg::PH_IDLE;
    phase_left  = '0;
    pulses_left = '0;
    moving_pos  = 1'b0;
    rec_edge    = pmstep_pkg::EDGE_NONE;
    drive_cut   = 1'b0;
    prev_sw     = 2'b00;
    since_edge  = 8'hFF;
    errors      = 0;
  endfunction

  function void set_reg(logic [pmstep_pkg::CfgIdxW-1:0] idx,
                        logic [pmstep_pkg::CfgDataW-1:0] val);
    case (idx)
      pmstep_pkg::CFG_ON_TICKS:       on_ticks = val;
      pmstep_pkg::CFG_OFF_TICKS:      off_ticks = val;
      pmstep_pkg::CFG_DEBOUNCE_TICKS: debounce = val[7:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return status_q.size();
  endfunction

  function bit busy();
    return phase != pmstep_pkg::PH_IDLE;
  endfunction

  function void start_pulse();
    phase      = pmstep_pkg::PH_ON;
    phase_left = (on_ticks == 16'd0) ? 16'd1 : on_ticks;
    drive_cut  = 1'b0;
  endfunction

  // returns 1 when no pulse is left and the command ends
  function bit advance_pulse();
    if (pulses_left == 16'd0) begin
      phase = pmstep_pkg::PH_IDLE;
      return 1'b1;
    end
    pulses_left = pulses_left - 16'd1;
    start_pulse();
    return 1'b0;
  endfunction

  function void note_cmd(pmstep_pkg::cmd_t c);
    logic [1:0]        sw;
    logic              done;
    logic              reached;
    logic              driving;
    pmstep_pkg::edge_t want;
    pmstep_pkg::res_t  r;
    sw      = {c.sw_neg, c.sw_pos};
    done    = 1'b0;
    reached = 1'b0;
    if (c.opcode == pmstep_pkg::OP_TICK && since_edge != 8'hFF)
      since_edge = since_edge + 8'd1;
    if (sw != prev_sw) begin
      if (since_edge > debounce) begin
        rec_edge  = c.sw_pos ? pmstep_pkg::EDGE_POS :
                    (c.sw_neg ? pmstep_pkg::EDGE_NEG : pmstep_pkg::EDGE_NONE);
        drive_cut = 1'b1;
      end
      since_edge = 8'd0;
    end
    prev_sw = sw;

    if (c.opcode == pmstep_pkg::OP_START) begin
      if (phase == pmstep_pkg::PH_IDLE) begin
        moving_pos = c.direction;
        if (c.direction ? c.sw_pos : c.sw_neg) begin
          done    = 1'b1;
          reached = 1'b1;
        end else if (c.step_count == 16'd0) begin
          done = 1'b1;
        end else begin
          pulses_left = c.step_count - 16'd1;
          start_pulse();
        end
      end
    end else if (phase == pmstep_pkg::PH_ON) begin
      phase_left = phase_left - 16'd1;
      if (phase_left == 16'd0) begin
        want = moving_pos ? pmstep_pkg::EDGE_POS : pmstep_pkg::EDGE_NEG;
        if (rec_edge == want) begin
          rec_edge = pmstep_pkg::EDGE_NONE;
          phase    = pmstep_pkg::PH_IDLE;
          done     = 1'b1;
          reached  = 1'b1;
        end else if (off_ticks == 16'd0) begin
          done = advance_pulse();
        end else begin
          phase      = pmstep_pkg::PH_OFF;
          phase_left = off_ticks;
        end
      end
    end else if (phase == pmstep_pkg::PH_OFF) begin
      phase_left = phase_left - 16'd1;
      if (phase_left == 16'd0) done = advance_pulse();
    end

    driving         = (phase == pmstep_pkg::PH_ON) && !drive_cut;
    r.drive_pos     = driving & moving_pos;
    r.drive_neg     = driving & ~moving_pos;
    r.busy_res      = phase != pmstep_pkg::PH_IDLE;
    r.done_res      = done;
    r.reached_limit = reached;
    status_q.push_back(r);
  endfunction

  task report(string what, logic got, logic want);
    $display("mismatch @%0t: %s got %b want %b", $time, what, got, want);
    errors++;
  endtask

  task check_res(pmstep_pkg::res_t got);
    pmstep_pkg::res_t want;
    if (status_q.size() == 0) begin
      $display("mismatch @%0t: result %b with no transaction pending", $time, got);
      errors++;
    end else begin
      want = status_q.pop_front();
      if (got.drive_pos !== want.drive_pos)
        report("drive_pos", got.drive_pos, want.drive_pos);
      if (got.drive_neg !== want.drive_neg)
        report("drive_neg", got.drive_neg, want.drive_neg);
      if (got.busy_res !== want.busy_res)
        report("busy_res", got.busy_res, want.busy_res);
      if (got.done_res !== want.done_res)
        report("done_res", got.done_res, want.done_res);
      if (got.reached_limit !== want.reached_limit)
        report("reached_limit", got.reached_limit, want.reached_limit);
    end
  endtask
endclass

module tb_pulsed_motor_step_with_limit_stop_unit;
  import pmstep_pkg::*;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cmd_valid = 1'b0;
  logic                cmd_ready;
  cmd_t                cmd       = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  res_t                res;
  logic                cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr  = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  motor_scoreboard sb;
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req    = 1'b0;
  int  hold_len    = 0;
  logic cur_sp     = 1'b0;
  logic cur_sn     = 1'b0;

  pulsed_motor_step_with_limit_stop_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("FAIL pulsed_motor_step_with_limit_stop_unit");
    $finish;
  end

  // result side: random stalls, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end else begin
        res_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_res(res);
  end

  function automatic cmd_t mk_cmd(logic op, logic dir, logic [15:0] cnt,
                                  logic sp, logic sn);
    cmd_t c;
    c.opcode     = op;
    c.direction  = dir;
    c.step_count = cnt;
    c.sw_pos     = sp;
    c.sw_neg     = sn;
    return c;
  endfunction

  // called at a clock edge; returns at the edge where the transaction is taken
  task automatic send_cmd(cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    sb.note_cmd(c);
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // run the motor back to idle, then let all results come out
  task automatic settle();
    while (sb.busy()) send_cmd(mk_cmd(OP_TICK, 1'b0, 16'd0, cur_sp, cur_sn));
    wait_drained();
    repeat (2) @(posedge clk);
  endtask

  task automatic write_config(logic [15:0] on_t, logic [15:0] off_t, logic [7:0] deb);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_ON_TICKS;
    cfg_wdata <= on_t;
    @(posedge clk);
    cfg_addr  <= CFG_OFF_TICKS;
    cfg_wdata <= off_t;
    @(posedge clk);
    cfg_addr  <= CFG_DEBOUNCE_TICKS;
    cfg_wdata <= {8'd0, deb};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(CFG_ON_TICKS, on_t);
    sb.set_reg(CFG_OFF_TICKS, off_t);
    sb.set_reg(CFG_DEBOUNCE_TICKS, {8'd0, deb});
    @(posedge clk);
  endtask

  task automatic run_random(int n, int hold_at, int pause_at);
    logic        dir;
    logic [15:0] cnt;
    logic        at_limit;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) begin
        hold_len = 300;
        hold_req = 1'b1;
      end
      if (i == pause_at) wait_drained();
      if ($urandom_range(99) < 6) cur_sp = ~cur_sp;
      if ($urandom_range(99) < 6) cur_sn = ~cur_sn;
      if (sb.busy()) begin
        // drive into the limit now and then so the stop path is reached
        if ($urandom_range(99) < 4) begin
          if (sb.moving_pos) cur_sp = 1'b1;
          else cur_sn = 1'b1;
        end
        if ($urandom_range(99) < 8)
          send_cmd(mk_cmd(OP_START, 1'($urandom_range(1)),
                          16'($urandom_range(16'hFFFF)), cur_sp, cur_sn));
        else
          send_cmd(mk_cmd(OP_TICK, 1'($urandom_range(1)),
                          16'($urandom_range(16'hFFFF)), cur_sp, cur_sn));
      end else if ($urandom_range(99) < 70) begin
        if ($urandom_range(99) < 70) begin
          cur_sp = 1'b0;
          cur_sn = 1'b0;
        end
        dir      = 1'($urandom_range(1));
        at_limit = dir ? cur_sp : cur_sn;
        // long counts only where the start finishes at once
        if (at_limit) cnt = 16'($urandom_range(16'hFFFF));
        else if ($urandom_range(99) < 5) cnt = 16'd0;
        else cnt = 16'($urandom_range(1, 6));
        send_cmd(mk_cmd(OP_START, dir, cnt, cur_sp, cur_sn));
      end else begin
        send_cmd(mk_cmd(OP_TICK, 1'($urandom_range(1)),
                        16'($urandom_range(16'hFFFF)), cur_sp, cur_sn));
      end
    end
  endtask

  initial begin
    cmd_t directed[$];
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 10;
    rx_idle_pct = 69;
    @(posedge clk);

    // one full pulse at the reset register values
    send_cmd(mk_cmd(OP_START, 1'b1, 16'd1, 1'b0, 1'b0));
    write_config(16'd2, 16'd1, 8'd0);

    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b1, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b1, 16'hFFFF, 1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b0, 16'hFFFF, 1'b1, 1'b1));
    directed.push_back(mk_cmd(OP_TICK,  1'b1, 16'hFFFF, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b1, 16'd2,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b0, 16'h5A5A, 1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b1, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b0, 16'd3,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b1));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b1));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b1));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_START, 1'b0, 16'd2,    1'b0, 1'b0));
    directed.push_back(mk_cmd(OP_TICK,  1'b0, 16'd0,    1'b0, 1'b0));
    foreach (directed[i]) send_cmd(directed[i]);
    cur_sp = 1'b0;
    cur_sn = 1'b0;

    write_config(16'd3, 16'd2, 8'd4);
    run_random(80, 30, -1);
    write_config(16'd0, 16'd0, 8'd0);
    run_random(80, -1, -1);

    tx_idle_pct = 69;
    rx_idle_pct = 10;
    write_config(16'd5, 16'd3, 8'd255);
    run_random(80, -1, 40);
    write_config(16'd2, 16'd1, 8'd1);
    run_random(80, -1, -1);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_config(16'd1, 16'd0, 8'd8);
    run_random(80, -1, -1);

    // long on-time with no rest, then a short pulse with a long rest
    write_config(16'd60, 16'd0, 8'd3);
    cur_sp = 1'b0;
    cur_sn = 1'b0;
    send_cmd(mk_cmd(OP_START, 1'b1, 16'd1, 1'b0, 1'b0));
    write_config(16'd1, 16'd40, 8'd255);
    send_cmd(mk_cmd(OP_START, 1'b0, 16'd1, 1'b0, 1'b0));
    settle();
    repeat (4) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS pulsed_motor_step_with_limit_stop_unit");
    end else begin
      $display("FAIL pulsed_motor_step_with_limit_stop_unit");
    end
    $finish;
  end
endmodule
